// ===== hdl/pfbp_pkg.sv =====
// Package for the packet frame byte parser.
// Holds widths, phase and error codes, reset values and shared types.
// Used by every module in hdl; depends on nothing.
`default_nettype none

package pfbp_pkg;

  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 3;
  localparam int CNT_W    = 31;
  localparam int WORD_W   = 32;
  localparam int ERR_W    = 3;
  localparam int HLEN_W   = 16;
  localparam int BLEN_W   = 31;
  localparam int MAGIC_W  = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;

  // parse phases, also the field code of the result word
  localparam logic [FIELD_W-1:0] PH_MAGIC    = 3'd0;
  localparam logic [FIELD_W-1:0] PH_TYPE     = 3'd1;
  localparam logic [FIELD_W-1:0] PH_SLEN     = 3'd2;
  localparam logic [FIELD_W-1:0] PH_SENDER   = 3'd3;
  localparam logic [FIELD_W-1:0] PH_RLEN     = 3'd4;
  localparam logic [FIELD_W-1:0] PH_RECEIVER = 3'd5;
  localparam logic [FIELD_W-1:0] PH_CLEN     = 3'd6;
  localparam logic [FIELD_W-1:0] PH_BODY     = 3'd7;

  localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MAGIC = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TYPE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HLEN  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BLEN  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HLEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLEN = 2'd3;

  localparam logic [MAGIC_W-1:0] MAGIC_RST    = 64'h0102_0304_0102_0304;
  localparam logic [WORD_W-1:0]  TYPE_RST     = 32'd0;
  localparam logic [HLEN_W-1:0]  MAX_HLEN_RST = 16'd256;
  localparam logic [BLEN_W-1:0]  MAX_BLEN_RST = 31'd65536;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic_word;
    logic [WORD_W-1:0]  expected_type;
    logic [HLEN_W-1:0]  max_header_len;
    logic [BLEN_W-1:0]  max_body_len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic [FIELD_W-1:0] field_code;
    logic [CNT_W-1:0]   bytes_needed;
    logic [WORD_W-1:0]  decoded_word;
    logic               packet_last;
    logic [ERR_W-1:0]   error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/pfbp_queue.sv =====
// Short byte queue between the accepting front and the parse engine.
// Depends on pfbp_pkg for the byte width.
`default_nettype none

module pfbp_queue #(
  parameter int DEPTH = pfbp_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [pfbp_pkg::BYTE_W-1:0] push_data,
  output logic                             full,
  input  wire logic                        pop,
  output logic                             not_empty,
  output logic [pfbp_pkg::BYTE_W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [pfbp_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/pfbp_engine.sv =====
// Parse engine: frame phase state, field counter, word assembly and the
// result register. Depends on pfbp_pkg for codes and the cfg_t/res_t types.
`default_nettype none

module pfbp_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pfbp_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire logic [pfbp_pkg::BYTE_W-1:0] q_byte,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output pfbp_pkg::res_t                   out_res
);

  logic [pfbp_pkg::FIELD_W-1:0] phase_r, phase_nxt;
  logic [pfbp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pfbp_pkg::WORD_W-1:0]  acc_r, acc_nxt;
  logic                         mis_r, mis_nxt;
  logic                         out_valid_r;
  pfbp_pkg::res_t               out_res_r, res_nxt;

  logic [2:0]                  magic_idx;
  logic [pfbp_pkg::BYTE_W-1:0] magic_exp;
  logic                        mis_any;
  logic [1:0]                  word_idx;
  logic [pfbp_pkg::WORD_W-1:0] acc_sh;
  logic [pfbp_pkg::CNT_W-1:0]  cnt_dec;

  // result register frees up when empty or being taken this cycle
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    magic_idx = cnt_r[2:0];
    magic_exp = pfbp_pkg::BYTE_W'(cfg.magic_word >> {~magic_idx, 3'b000});
    mis_any   = mis_r | (magic_exp != q_byte);
    word_idx  = cnt_r[1:0];
    acc_sh    = {acc_r[pfbp_pkg::WORD_W-9:0], q_byte};
    cnt_dec   = (cnt_r != '0) ? cnt_r - pfbp_pkg::CNT_W'(1) : '0;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mis_nxt   = mis_r;

    res_nxt.byte_out     = q_byte;
    res_nxt.field_code   = phase_r;
    res_nxt.bytes_needed = '0;
    res_nxt.decoded_word = '0;
    res_nxt.packet_last  = 1'b0;
    res_nxt.error_code   = pfbp_pkg::ERR_NONE;

    case (phase_r)
      pfbp_pkg::PH_MAGIC: begin
        res_nxt.bytes_needed = pfbp_pkg::CNT_W'(3'd7 - magic_idx);
        if (magic_idx == 3'd7) begin
          // eighth byte: pass on a clean match, else report and retry
          if (mis_any) begin
            res_nxt.error_code = pfbp_pkg::ERR_MAGIC;
          end else begin
            phase_nxt = pfbp_pkg::PH_TYPE;
          end
          cnt_nxt = '0;
          mis_nxt = 1'b0;
          acc_nxt = '0;
        end else begin
          cnt_nxt = pfbp_pkg::CNT_W'(magic_idx) + pfbp_pkg::CNT_W'(1);
          mis_nxt = mis_any;
        end
      end
      pfbp_pkg::PH_TYPE, pfbp_pkg::PH_SLEN, pfbp_pkg::PH_RLEN, pfbp_pkg::PH_CLEN: begin
        res_nxt.decoded_word = acc_sh;
        res_nxt.bytes_needed = pfbp_pkg::CNT_W'(2'd3 - word_idx);
        if (word_idx == 2'd3) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (phase_r == pfbp_pkg::PH_TYPE) begin
            if (acc_sh != cfg.expected_type) begin
              res_nxt.error_code = pfbp_pkg::ERR_TYPE;
            end else begin
              phase_nxt = pfbp_pkg::PH_SLEN;
            end
          end else if (phase_r == pfbp_pkg::PH_CLEN) begin
            if (acc_sh > pfbp_pkg::WORD_W'(cfg.max_body_len)) begin
              res_nxt.error_code = pfbp_pkg::ERR_BLEN;
            end else if (acc_sh == '0) begin
              phase_nxt           = pfbp_pkg::PH_MAGIC;
              res_nxt.packet_last = 1'b1;
            end else begin
              phase_nxt = pfbp_pkg::PH_BODY;
              cnt_nxt   = acc_sh[pfbp_pkg::CNT_W-1:0];
            end
          end else begin
            if (acc_sh > pfbp_pkg::WORD_W'(cfg.max_header_len)) begin
              res_nxt.error_code = pfbp_pkg::ERR_HLEN;
            end else if (acc_sh == '0) begin
              // empty sender or receiver: go straight to the next length
              phase_nxt = phase_r + pfbp_pkg::FIELD_W'(2);
            end else begin
              phase_nxt = phase_r + pfbp_pkg::FIELD_W'(1);
              cnt_nxt   = acc_sh[pfbp_pkg::CNT_W-1:0];
            end
          end
        end else begin
          cnt_nxt = pfbp_pkg::CNT_W'(word_idx) + pfbp_pkg::CNT_W'(1);
          acc_nxt = acc_sh;
        end
      end
      default: begin
        // sender, receiver and body count down
        cnt_nxt              = cnt_dec;
        res_nxt.bytes_needed = cnt_dec;
        if (cnt_dec == '0) begin
          acc_nxt = '0;
          if (phase_r == pfbp_pkg::PH_BODY) begin
            phase_nxt           = pfbp_pkg::PH_MAGIC;
            mis_nxt             = 1'b0;
            res_nxt.packet_last = 1'b1;
          end else begin
            phase_nxt = phase_r + pfbp_pkg::FIELD_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pfbp_pkg::PH_MAGIC;
      cnt_r       <= '0;
      acc_r       <= '0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        acc_r   <= acc_nxt;
        mis_r   <= mis_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ===== hdl/packet_frame_byte_parser_top.sv =====
// Packet frame byte parser, top level. An accepted word passes through the
// queue, then the result register, to the out_ ports. Throughput: one word
// per cycle while out_stall is low; the engine's per-byte phase step,
// counter and compare are combinational. in_stall rises only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue and result register,
// returns to the magic phase and loads the register reset values.
`default_nettype none

module packet_frame_byte_parser_top #(
  parameter int QUEUE_DEPTH = pfbp_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [pfbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // byte input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pfbp_pkg::BYTE_W-1:0]      in_data_byte,
  // tagged byte output
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pfbp_pkg::BYTE_W-1:0]           out_byte_out,
  output logic [pfbp_pkg::FIELD_W-1:0]          out_field_code,
  output logic [pfbp_pkg::CNT_W-1:0]            out_bytes_needed,
  output logic [pfbp_pkg::WORD_W-1:0]           out_decoded_word,
  output logic                                  out_packet_last,
  output logic [pfbp_pkg::ERR_W-1:0]            out_error_code
);

  pfbp_pkg::cfg_t cfg_r;
  pfbp_pkg::res_t res;

  logic                        q_full;
  logic                        q_valid;
  logic                        q_pop;
  logic [pfbp_pkg::BYTE_W-1:0] q_byte;
  logic                        push;

  // Config registers. Writes must come only while the parser is idle; the block
  // does not enforce this and has no shadowing. Unused data bits of narrower registers are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word     <= pfbp_pkg::MAGIC_RST;
      cfg_r.expected_type  <= pfbp_pkg::TYPE_RST;
      cfg_r.max_header_len <= pfbp_pkg::MAX_HLEN_RST;
      cfg_r.max_body_len   <= pfbp_pkg::MAX_BLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfbp_pkg::REG_MAGIC:    cfg_r.magic_word     <= cfg_data;
        pfbp_pkg::REG_TYPE:     cfg_r.expected_type  <= cfg_data[pfbp_pkg::WORD_W-1:0];
        pfbp_pkg::REG_MAX_HLEN: cfg_r.max_header_len <= cfg_data[pfbp_pkg::HLEN_W-1:0];
        pfbp_pkg::REG_MAX_BLEN: cfg_r.max_body_len   <= cfg_data[pfbp_pkg::BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept whenever the queue has room. Stall comes from a register
  // inside the queue, never from out_stall combinationally.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  pfbp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data_byte),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_byte)
  );

  // Back: one byte per cycle through the phase logic into the result reg, unless out_stall holds it.
  pfbp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_byte    (q_byte),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_byte_out     = res.byte_out;
  assign out_field_code   = res.field_code;
  assign out_bytes_needed = res.bytes_needed;
  assign out_decoded_word = res.decoded_word;
  assign out_packet_last  = res.packet_last;
  assign out_error_code   = res.error_code;

endmodule

`default_nettype wire

// ===== hdl/pfbp_checker.sv =====
// Port-level checker for the packet frame byte parser, with its bind.
// Depends on pfbp_pkg for widths and codes.
`default_nettype none

module pfbp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [pfbp_pkg::BYTE_W-1:0]    out_byte_out,
  input wire logic [pfbp_pkg::FIELD_W-1:0]   out_field_code,
  input wire logic [pfbp_pkg::CNT_W-1:0]     out_bytes_needed,
  input wire logic [pfbp_pkg::WORD_W-1:0]    out_decoded_word,
  input wire logic                           out_packet_last,
  input wire logic [pfbp_pkg::ERR_W-1:0]     out_error_code
);

  // a packet only closes on a clean byte, at the end of body or content len
  a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_last |->
      out_error_code == pfbp_pkg::ERR_NONE && out_bytes_needed == '0 &&
      (out_field_code == pfbp_pkg::PH_BODY || out_field_code == pfbp_pkg::PH_CLEN))
    else $error("packet_last on a byte that cannot close a packet");

  // magic errors only on the eighth magic byte
  a_magic_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == pfbp_pkg::ERR_MAGIC |->
      out_field_code == pfbp_pkg::PH_MAGIC && out_bytes_needed == '0)
    else $error("magic error outside the last magic byte");

  // no assembled word outside type and length fields
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_field_code == pfbp_pkg::PH_MAGIC ||
                  out_field_code == pfbp_pkg::PH_SENDER ||
                  out_field_code == pfbp_pkg::PH_RECEIVER ||
                  out_field_code == pfbp_pkg::PH_BODY) |->
      out_decoded_word == '0)
    else $error("decoded word set in a byte field");

  // after a clean magic byte mid-field, the next word stays in magic
  a_magic_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_field_code == pfbp_pkg::PH_MAGIC &&
      out_bytes_needed != '0 ##1 out_valid |->
      out_field_code == pfbp_pkg::PH_MAGIC)
    else $error("left magic phase before its eighth byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_out) &&
      $stable(out_field_code))
    else $error("stalled output word changed");

endmodule

bind packet_frame_byte_parser_top pfbp_checker u_pfbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte_out     (out_byte_out),
  .out_field_code   (out_field_code),
  .out_bytes_needed (out_bytes_needed),
  .out_decoded_word (out_decoded_word),
  .out_packet_last  (out_packet_last),
  .out_error_code   (out_error_code)
);

`default_nettype wire

// ===== test/packet_frame_byte_parser_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the packet frame byte parser: models the deframer per word.
// Watches the cfg, in_ and out_ ports of the block; uses types from pfbp_pkg.
module packet_frame_byte_parser_checker
  import pfbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [BYTE_W-1:0]     out_byte_out,
  input  logic [FIELD_W-1:0]    out_field_code,
  input  logic [CNT_W-1:0]      out_bytes_needed,
  input  logic [WORD_W-1:0]     out_decoded_word,
  input  logic                  out_packet_last,
  input  logic [ERR_W-1:0]      out_error_code,
  output int                    failures,
  output int                    pending,
  output int                    results_seen,
  output int                    packets_seen,
  output int                    errors_seen
);

  // register copies
  logic [MAGIC_W-1:0] magic_want;
  logic [WORD_W-1:0]  type_want;
  logic [HLEN_W-1:0]  hlen_max;
  logic [BLEN_W-1:0]  blen_max;

  // deframer state
  logic [FIELD_W-1:0] phase;
  logic [31:0]        field_cnt;
  logic [31:0]        word_acc;
  logic               magic_bad;

  res_t tagged_words[$];

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output res_t r);
    logic [2:0]  idx;
    logic [31:0] v;
    r = '0;
    r.byte_out   = b;
    r.field_code = phase;
    case (phase)
      PH_MAGIC: begin
        idx = field_cnt[2:0];
        if (magic_want[8*(7-idx) +: 8] != b) magic_bad = 1'b1;
        field_cnt = 32'(idx) + 32'd1;
        r.bytes_needed = 31'(32'd8 - field_cnt);
        if (field_cnt == 32'd8) begin
          if (magic_bad) r.error_code = ERR_MAGIC;
          else phase = PH_TYPE;
          field_cnt = '0;
          magic_bad = 1'b0;
          word_acc  = '0;
        end
      end
      PH_TYPE, PH_SLEN, PH_RLEN, PH_CLEN: begin
        word_acc = {word_acc[23:0], b};
        r.decoded_word = word_acc;
        field_cnt = 32'(field_cnt[1:0]) + 32'd1;
        r.bytes_needed = 31'(32'd4 - field_cnt);
        if (field_cnt == 32'd4) begin
          v = word_acc;
          field_cnt = '0;
          word_acc  = '0;
          if (phase == PH_TYPE) begin
            if (v != type_want) r.error_code = ERR_TYPE;
            else phase = PH_SLEN;
          end else if (phase == PH_CLEN) begin
            if (v > 32'(blen_max)) begin
              r.error_code = ERR_BLEN;
            end else if (v == 32'd0) begin
              phase = PH_MAGIC;
              r.packet_last = 1'b1;
            end else begin
              phase = PH_BODY;
              field_cnt = v;
            end
          end else begin
            if (v > 32'(hlen_max)) begin
              r.error_code = ERR_HLEN;
            end else if (v == 32'd0) begin
              phase = (phase == PH_SLEN) ? PH_RLEN : PH_CLEN;
            end else begin
              phase = phase + 3'd1;
              field_cnt = v;
            end
          end
        end
      end
      default: begin
        // sender, receiver or body: count down the remaining bytes
        if (field_cnt != 32'd0) field_cnt = field_cnt - 32'd1;
        r.bytes_needed = field_cnt[30:0];
        if (field_cnt == 32'd0) begin
          word_acc = '0;
          case (phase)
            PH_SENDER:   phase = PH_RLEN;
            PH_RECEIVER: phase = PH_CLEN;
            default: begin
              phase = PH_MAGIC;
              magic_bad = 1'b0;
              r.packet_last = 1'b1;
            end
          endcase
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    logic wrong;
    if (!rst_n) begin
      magic_want = MAGIC_RST;
      type_want  = TYPE_RST;
      hlen_max   = MAX_HLEN_RST;
      blen_max   = MAX_BLEN_RST;
      phase      = PH_MAGIC;
      field_cnt  = '0;
      word_acc   = '0;
      magic_bad  = 1'b0;
      tagged_words.delete();
      failures     = 0;
      results_seen = 0;
      packets_seen = 0;
      errors_seen  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAGIC:    magic_want = cfg_data;
          REG_TYPE:     type_want  = cfg_data[WORD_W-1:0];
          REG_MAX_HLEN: hlen_max   = cfg_data[HLEN_W-1:0];
          REG_MAX_BLEN: blen_max   = cfg_data[BLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.byte_out     = out_byte_out;
        got.field_code   = out_field_code;
        got.bytes_needed = out_bytes_needed;
        got.decoded_word = out_decoded_word;
        got.packet_last  = out_packet_last;
        got.error_code   = out_error_code;
        results_seen++;
        if (out_packet_last === 1'b1) packets_seen++;
        if (out_error_code !== ERR_NONE) errors_seen++;
        if (tagged_words.size() == 0) begin
          if (failures < 10)
            $display("%t: result word with nothing pending: byte %02h field %0d",
                     $realtime, got.byte_out, got.field_code);
          failures++;
        end else begin
          want = tagged_words.pop_front();
          wrong = (got.byte_out !== want.byte_out) ||
                  (got.field_code !== want.field_code) ||
                  (got.bytes_needed !== want.bytes_needed) ||
                  (got.decoded_word !== want.decoded_word) ||
                  (got.packet_last !== want.packet_last) ||
                  (got.error_code !== want.error_code);
          if (wrong) begin
            if (failures < 10) begin
              $display("%t: result %0d differs", $realtime, results_seen);
              $display("  expected byte %02h field %0d need %0d word %08h last %0b err %0d",
                       want.byte_out, want.field_code, want.bytes_needed,
                       want.decoded_word, want.packet_last, want.error_code);
              $display("  actual   byte %02h field %0d need %0d word %08h last %0b err %0d",
                       got.byte_out, got.field_code, got.bytes_needed,
                       got.decoded_word, got.packet_last, got.error_code);
            end
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte, want);
        tagged_words.push_back(want);
      end
    end
    pending <= tagged_words.size();
  end

endmodule

// ===== test/packet_frame_byte_parser_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for packet_frame_byte_parser_top: drives frames and registers.
// Needs pfbp_pkg, the block and packet_frame_byte_parser_checker.
module packet_frame_byte_parser_top_tb;
  import pfbp_pkg::*;

  // fault selects for a frame: a bad attempt precedes the good field
  localparam int F_MAGIC = 0;
  localparam int F_TYPE  = 1;
  localparam int F_SLEN  = 2;
  localparam int F_RLEN  = 3;
  localparam int F_CLEN  = 4;

  localparam int SETTING_PHASES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_byte_out;
  logic [FIELD_W-1:0]    out_field_code;
  logic [CNT_W-1:0]      out_bytes_needed;
  logic [WORD_W-1:0]     out_decoded_word;
  logic                  out_packet_last;
  logic [ERR_W-1:0]      out_error_code;

  int failures, pending, results_seen, packets_seen, errors_seen;

  // words handed to the block so far
  int n_sent = 0;
  // when set, neither side idles or stalls
  bit calm = 1'b0;

  // register values currently loaded, used to build well-formed frames
  logic [63:0] cur_magic = MAGIC_RST;
  logic [31:0] cur_type  = TYPE_RST;
  logic [31:0] cur_hlen  = 32'(MAX_HLEN_RST);
  logic [31:0] cur_blen  = 32'(MAX_BLEN_RST);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packet_frame_byte_parser_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_field_code   (out_field_code),
    .out_bytes_needed (out_bytes_needed),
    .out_decoded_word (out_decoded_word),
    .out_packet_last  (out_packet_last),
    .out_error_code   (out_error_code)
  );

  packet_frame_byte_parser_checker scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_field_code   (out_field_code),
    .out_bytes_needed (out_bytes_needed),
    .out_decoded_word (out_decoded_word),
    .out_packet_last  (out_packet_last),
    .out_error_code   (out_error_code),
    .failures         (failures),
    .pending          (pending),
    .results_seen     (results_seen),
    .packets_seen     (packets_seen),
    .errors_seen      (errors_seen)
  );

  // Receiver: stalls on about ten percent of cycles, never during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // One word on the input channel. Valid may drop for a short gap first;
  // in_stall read right after the edge is the value the block sampled.
  task automatic send_byte(input logic [7:0] b);
    int r;
    r = $urandom_range(99);
    if (!calm && r < 10) begin
      in_valid <= 1'b0;
      repeat ((r < 8) ? 1 : $urandom_range(6, 2)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // type and length fields go out big-endian
  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_magic(input logic [63:0] m);
    for (int i = 7; i >= 0; i--) send_byte(m[8*i +: 8]);
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // A length just above the limit, all ones (tests unsigned compare) or
  // anything in between.
  function automatic logic [31:0] over_limit(input logic [31:0] lim);
    logic [31:0] room;
    room = 32'hFFFF_FFFF - lim - 32'd1;
    case ($urandom_range(2))
      0:       return lim + 32'd1;
      1:       return 32'hFFFF_FFFF;
      default: return lim + 32'd1 + $urandom_range(room);
    endcase
  endfunction

  // Mostly short fields; zero and the limit itself show up often when the
  // limit is small.
  function automatic int unsigned pick_len(input logic [31:0] lim);
    int unsigned cap;
    int r;
    cap = (lim < 32'd48) ? lim : 48;
    r = $urandom_range(9);
    if (r < 2) return 0;
    if (r == 2) return cap;
    return $urandom_range(cap);
  endfunction

  // Full frame. Each selected fault sends one bad copy of the field first;
  // the block reports it and restarts that same field, so the good copy
  // that follows lines the stream back up.
  task automatic send_frame(input int unsigned slen, input int unsigned rlen,
                            input int unsigned blen, input logic [4:0] faults);
    if (faults[F_MAGIC]) send_magic(cur_magic ^ (64'h1 << $urandom_range(63)));
    send_magic(cur_magic);
    if (faults[F_TYPE]) send_word(cur_type ^ (32'h1 << $urandom_range(31)));
    send_word(cur_type);
    if (faults[F_SLEN]) send_word(over_limit(cur_hlen));
    send_word(slen);
    send_payload(slen);
    if (faults[F_RLEN]) send_word(over_limit(cur_hlen));
    send_word(rlen);
    send_payload(rlen);
    if (faults[F_CLEN]) send_word(over_limit(cur_blen));
    send_word(blen);
    send_payload(blen);
  endtask

  // Hold the sender until every tagged word is back, then let the queue and
  // output register go quiet. pending is updated with a nonblocking write, so
  // the task waits for a clock edge before it first looks.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays up across back-to-back writes; caller lowers it
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] m, input logic [31:0] t,
                           input logic [15:0] h, input logic [30:0] b);
    drain;
    put_reg(REG_MAGIC, m);
    put_reg(REG_TYPE, t);
    put_reg(REG_MAX_HLEN, h);
    put_reg(REG_MAX_BLEN, b);
    cfg_we    <= 1'b0;
    cur_magic = m;
    cur_type  = t;
    cur_hlen  = 32'(h);
    cur_blen  = 32'(b);
  endtask

  initial begin : stimulus
    int unsigned target;
    int r;
    logic [4:0] faults;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset register values ---
    // all lengths zero: packet ends on the last content length byte
    send_frame(0, 0, 0, '0);
    // magic with one wrong byte, then a one-byte sender, receiver and body
    send_magic(cur_magic ^ 64'h80);
    send_frame(1, 1, 1, '0);
    // type and length field errors in turn, each field restarted with a good value;
    // sender length exactly at the limit, receiver skipped
    send_magic(cur_magic);
    send_word(32'hFFFF_FFFF);
    send_word(cur_type);
    send_word(cur_hlen + 32'd1);
    send_word(cur_hlen);
    send_payload(cur_hlen);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'h8000_0000);
    send_word(cur_blen + 32'd1);
    send_word(32'd2);
    send_payload(2);

    // --- random frames over several register settings ---
    for (int ph = 0; ph < SETTING_PHASES; ph++) begin
      case (ph)
        0: configure(64'h0, 32'hFFFF_FFFF, 16'd0, 31'd0);
        1: configure(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'hFFFF, 31'h7FFF_FFFF);
        default: configure({$urandom, $urandom}, $urandom,
                           16'($urandom_range(40)), 31'($urandom_range(64)));
      endcase
      calm = (ph == 3);
      target = n_sent + 200;
      while (n_sent < target) begin
        r = $urandom_range(99);
        if (r < 10) begin
          // line noise in whole magic-sized groups keeps framing aligned
          send_payload(8 * $urandom_range(3, 1));
        end else begin
          faults = (r < 30) ? 5'($urandom_range(31, 1)) : '0;
          send_frame(pick_len(cur_hlen), pick_len(cur_hlen), pick_len(cur_blen), faults);
        end
      end
    end
    calm = 1'b0;

    drain;
    $display("Sent %0d words over %0d register settings; %0d results checked",
             n_sent, SETTING_PHASES + 1, results_seen);
    $display("%0d packets completed, %0d errors flagged", packets_seen, errors_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pfbp_pkg.sv
hdl/pfbp_queue.sv
hdl/pfbp_engine.sv
hdl/packet_frame_byte_parser_top.sv
hdl/pfbp_checker.sv
test/packet_frame_byte_parser_checker.sv
test/packet_frame_byte_parser_top_tb.sv
